@@ hdl/ring_buffer_deque_unit_assert.svh @@
// Assertion macros for the deque block.
`ifndef RING_BUFFER_DEQUE_UNIT_ASSERT_SVH
`define RING_BUFFER_DEQUE_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define RBD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deque assertion failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define RBD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deque assertion failed");

`endif

@@ hdl/rbd_pkg.sv @@
`default_nettype none

package rbd_pkg;

    localparam int DEPTH_DEF      = 16;
    localparam int DATA_WIDTH_DEF = 32;

    typedef enum logic [2:0] {
        CMD_PUSH_BACK  = 3'd0,
        CMD_PUSH_FRONT = 3'd1,
        CMD_POP_BACK   = 3'd2,
        CMD_POP_FRONT  = 3'd3,
        CMD_PEEK_BACK  = 3'd4,
        CMD_PEEK_FRONT = 3'd5,
        CMD_READ_INDEX = 3'd6,
        CMD_CLEAR      = 3'd7
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

    // Broadcast to every cell of the chain.
    typedef struct packed {
        logic push_front;   // take the word from the front-side neighbor
        logic pop_front;    // take the word from the back-side neighbor
        logic push_back;    // load the new word if this cell is the tail slot
    } cell_ctrl_t;

endpackage

`default_nettype wire

@@ hdl/rbd_cell.sv @@
`default_nettype none

module rbd_cell
    import rbd_pkg::*;
#(
    parameter int IDX        = 0,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int CNT_W      = 5
)
(
    input  wire logic                  clk,
    input  wire cell_ctrl_t            ctrl,
    input  wire logic [CNT_W-1:0]      count,
    input  wire logic [DATA_WIDTH-1:0] data_in,
    input  wire logic [DATA_WIDTH-1:0] left_data,
    input  wire logic [DATA_WIDTH-1:0] right_data,
    output logic      [DATA_WIDTH-1:0] q
);

    localparam logic [CNT_W-1:0] MY_SLOT = CNT_W'(IDX);

    logic [DATA_WIDTH-1:0] q_reg;
    logic [DATA_WIDTH-1:0] q_next;

    always_comb
    begin
        q_next = q_reg;
        if (ctrl.push_front)
        begin
            q_next = left_data;
        end
        else if (ctrl.pop_front)
        begin
            q_next = right_data;
        end
        else if (ctrl.push_back && (count == MY_SLOT))
        begin
            q_next = data_in;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

    assign q = q_reg;

endmodule

`default_nettype wire

@@ hdl/ring_buffer_deque_unit.sv @@
// Double-ended queue of DATA_WIDTH-bit words, up to DEPTH entries, limited to the number
// set by the capacity register (0 acts as 1, values above DEPTH act as DEPTH). Entries sit
// in a chain of cells ordered from the front: push front and pop front shift the whole
// chain by one cell, push back loads the cell at the tail. Every command gives one result
// (data, status, occupancy after the command) in the cycle after it is taken; the result
// register lets a new command in each cycle while out_ready is high, so the rate is one
// command per cycle, set by the single chain update per cycle. A capacity write empties
// the queue. After reset the queue is empty and capacity is DEPTH; no clearing pass.
`default_nettype none
`include "ring_buffer_deque_unit_assert.svh"

module ring_buffer_deque_unit
    import rbd_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    localparam int CNT_W     = $clog2(DEPTH + 1),
    localparam int IDX_W     = $clog2(DEPTH)
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CNT_W-1:0]      capacity,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [2:0]            cmd,
    input  wire logic [DATA_WIDTH-1:0] data_in,
    input  wire logic [IDX_W-1:0]      position,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic      [DATA_WIDTH-1:0] data_out,
    output logic      [1:0]            status,
    output logic      [CNT_W-1:0]      occupancy
);

    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);
    localparam logic [CNT_W-1:0] ONE_C   = CNT_W'(1);

    logic [CNT_W-1:0]      capacity_reg;
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    logic                  res_valid_reg;
    logic [DATA_WIDTH-1:0] data_out_reg;
    logic [DATA_WIDTH-1:0] data_out_next;
    status_t               status_reg;
    status_t               status_next;
    logic [CNT_W-1:0]      occupancy_reg;

    logic [CNT_W-1:0]      cap_eff;
    logic                  accept;
    logic                  full;
    logic                  empty;
    cmd_t                  cmd_code;
    logic [IDX_W-1:0]      rd_idx;
    logic [DATA_WIDTH-1:0] rd_data;
    cell_ctrl_t            ctrl;
    logic [DATA_WIDTH-1:0] cell_q [DEPTH];

    assign in_ready = !res_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;
    assign cmd_code = cmd_t'(cmd);

    always_comb
    begin
        if (capacity_reg == '0)
        begin
            cap_eff = ONE_C;
        end
        else if (capacity_reg > DEPTH_C)
        begin
            cap_eff = DEPTH_C;
        end
        else
        begin
            cap_eff = capacity_reg;
        end
    end

    assign full  = (count_reg >= cap_eff);
    assign empty = (count_reg == '0);

    // Pick the one cell the command reads.
    always_comb
    begin
        case (cmd_code)
            CMD_POP_BACK, CMD_PEEK_BACK: rd_idx = IDX_W'(count_reg - ONE_C);
            CMD_READ_INDEX:              rd_idx = position;
            default:                     rd_idx = '0;
        endcase
    end

    assign rd_data = cell_q[rd_idx];

    always_comb
    begin
        count_next    = count_reg;
        data_out_next = '0;
        status_next   = ST_OK;
        ctrl          = '0;
        case (cmd_code)
            CMD_PUSH_BACK, CMD_PUSH_FRONT:
            begin
                if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    count_next      = count_reg + ONE_C;
                    ctrl.push_front = accept && (cmd_code == CMD_PUSH_FRONT);
                    ctrl.push_back  = accept && (cmd_code == CMD_PUSH_BACK);
                end
            end
            CMD_POP_BACK, CMD_POP_FRONT:
            begin
                if (empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    data_out_next  = rd_data;
                    count_next     = count_reg - ONE_C;
                    ctrl.pop_front = accept && (cmd_code == CMD_POP_FRONT);
                end
            end
            CMD_PEEK_BACK, CMD_PEEK_FRONT:
            begin
                if (empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    data_out_next = rd_data;
                end
            end
            CMD_READ_INDEX:
            begin
                if (CNT_W'(position) >= count_reg)
                begin
                    status_next = ST_RANGE;
                end
                else
                begin
                    data_out_next = rd_data;
                end
            end
            CMD_CLEAR:
            begin
                count_next = '0;
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [DATA_WIDTH-1:0] left_w;
        logic [DATA_WIDTH-1:0] right_w;

        if (i == 0)
        begin : g_head
            assign left_w = data_in;
        end
        else
        begin : g_mid_l
            assign left_w = cell_q[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_tail
            assign right_w = cell_q[i];
        end
        else
        begin : g_mid_r
            assign right_w = cell_q[i+1];
        end

        rbd_cell #(
            .IDX        (i),
            .DATA_WIDTH (DATA_WIDTH),
            .CNT_W      (CNT_W)
        ) u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .count      (count_reg),
            .data_in    (data_in),
            .left_data  (left_w),
            .right_data (right_w),
            .q          (cell_q[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg  <= DEPTH_C;
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                // Capacity change empties the queue.
                capacity_reg <= capacity;
                count_reg    <= '0;
            end
            else if (accept)
            begin
                count_reg <= count_next;
            end

            if (accept)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            data_out_reg  <= data_out_next;
            status_reg    <= status_next;
            occupancy_reg <= count_next;
        end
    end

    assign out_valid = res_valid_reg;
    assign data_out  = data_out_reg;
    assign status    = status_reg;
    assign occupancy = occupancy_reg;

    `RBD_ASSERT_NOW(a_count_within_ring, 1'b1, count_reg <= cap_eff)
    `RBD_ASSERT_NOW(a_zero_data_on_error, res_valid_reg && (status_reg != ST_OK),
        data_out_reg == '0)
    `RBD_ASSERT_NEXT(a_push_grows, accept && !cfg_we && !full &&
        ((cmd_code == CMD_PUSH_BACK) || (cmd_code == CMD_PUSH_FRONT)),
        count_reg == $past(count_reg) + ONE_C)

endmodule

`default_nettype wire
